// ===== rtl/core/ufr_pkg.sv =====
// shared types and byte codes of the uart frame receiver
package ufr_pkg;

    localparam logic [7:0] HDR_BYTE = 8'hAA;
    localparam logic [7:0] TRL_BYTE = 8'h55;
    localparam logic [7:0] RTX_BYTE = 8'hE1;
    localparam int unsigned FIRST_BODY = 3;
    localparam int unsigned MIN_CLOSE_POS = 4;

    // result flag bits carried in tuser
    typedef struct packed {
        logic retransmit_request;
        logic send_nak;
        logic byte_valid;
    } t_out_user;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD
    } t_state;

endpackage

// ===== rtl/core/uart_frame_receiver.sv =====
// uart frame receiver: header hunt, frame store in memory, checksum check and readout
//
// channel   | dir | tdata              | tuser (low bit up)                                   | tlast
// s (rx)    | in  | [7:0] rx_byte      | [0] framing_error                                    | -
// m (frame) | out | [7:0] frame_byte   | [0] byte_valid [1] send_nak [2] retransmit_request  | last_byte
//
// a received byte is taken only while idle; bytes are written to the frame store as they arrive
// readout of an accepted frame goes through ST_READ (the store read) and ST_LOAD (the output
// register load) for each byte, and no input is taken until the last byte is loaded
// reset (synchronous, active low) clears control state only; store contents are not cleared
// a stalled output holds its request and blocks both readout and input
module uart_frame_receiver #(
    parameter int unsigned MAX_FILL = 20
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] rx_byte
    input  logic [0:0] i_s_tuser,   // [0] framing_error
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] frame_byte
    output logic       o_m_tlast,
    output logic [2:0] o_m_tuser    // [0] byte_valid [1] send_nak [2] retransmit_request
);
    import ufr_pkg::*;

    localparam int unsigned PW = $clog2(MAX_FILL + 2);
    localparam int unsigned AW = $clog2(MAX_FILL + 1);

    logic [7:0]    r_mem [0:MAX_FILL];
    logic [7:0]    r_rd_data;

    t_state        r_state, n_state;
    logic [PW-1:0] r_fill, n_fill;
    logic          r_in_frame, n_in_frame;
    logic [7:0]    r_sum, n_sum;
    logic [7:0]    r_b1, r_b2;
    logic [AW-1:0] r_rd_addr, r_last_addr;

    logic          r_out_valid;
    logic [7:0]    r_out_byte;
    logic          r_out_last;
    t_out_user     r_out_user;

    logic          w_slot_free, w_acc, w_load_byte, w_rd_done;
    logic [7:0]    w_b, w_sum_new, w_s;
    logic [PW-1:0] w_pos, w_pos_m1, w_pos_m2;
    logic          w_trailer, w_ok_norm, w_ok_alt, w_ok;
    logic          w_flag_load, w_we;
    t_out_user     w_flag_user;

    assign w_slot_free = !r_out_valid || i_m_tready;
    assign w_acc       = i_s_tvalid && o_s_tready && !i_s_tuser[0];
    assign w_b         = i_s_tdata;
    assign w_rd_done   = (r_rd_addr == r_last_addr);

    // per-byte datapath
    assign w_pos     = r_fill + PW'(1);
    assign w_pos_m1  = w_pos - PW'(1);
    assign w_pos_m2  = w_pos - PW'(2);
    assign w_sum_new = r_sum + w_b;
    assign w_s       = w_sum_new - HDR_BYTE;
    // r_b1 and r_b2 shadow the store at the two positions before this one
    assign w_trailer = r_in_frame && (w_b == TRL_BYTE) && (w_pos > PW'(MIN_CLOSE_POS))
                    && (w_pos <= PW'(MAX_FILL + 1)) && (r_b1 == TRL_BYTE);
    assign w_ok_norm = ((w_s - r_b2) == r_b2);
    assign w_ok_alt  = (w_s == TRL_BYTE);
    assign w_ok      = w_ok_norm || w_ok_alt;
    assign w_we      = w_acc && (r_in_frame || (w_b == HDR_BYTE)) && (w_pos <= PW'(MAX_FILL));

    always_comb begin
        w_flag_user = '0;
        w_flag_load = 1'b0;
        n_fill      = r_fill;
        n_in_frame  = r_in_frame;
        n_sum       = r_sum;
        if (w_acc) begin
            if (r_in_frame) begin
                n_fill = w_pos;
                n_sum  = w_sum_new;
                if (w_trailer) begin
                    n_fill     = '0;
                    n_in_frame = 1'b0;
                    n_sum      = '0;
                    if (!w_ok) begin
                        w_flag_load          = 1'b1;
                        w_flag_user.send_nak = 1'b1;
                    end
                end else if (w_pos > PW'(MAX_FILL)) begin
                    // overlong frame dropped, sum carries over
                    n_fill     = '0;
                    n_in_frame = 1'b0;
                end
            end else if (w_b == HDR_BYTE) begin
                n_fill = w_pos;
                if (w_pos == PW'(2)) begin
                    n_in_frame = 1'b1;
                end
            end else begin
                n_fill = '0;
                if (w_b == RTX_BYTE) begin
                    w_flag_load                    = 1'b1;
                    w_flag_user.retransmit_request = 1'b1;
                end
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_acc && w_trailer && w_ok) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                if (w_slot_free) begin
                    n_state = w_rd_done ? ST_IDLE : ST_READ;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        o_s_tready  = 1'b0;
        w_load_byte = 1'b0;
        case (r_state)
            ST_IDLE: o_s_tready  = w_slot_free;
            ST_READ: w_load_byte = 1'b0;
            ST_LOAD: w_load_byte = w_slot_free;
            default: o_s_tready  = 1'b0;
        endcase
    end

    // frame store
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_pos[AW-1:0]] <= w_b;
        end
        r_rd_data <= r_mem[r_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_in_frame  <= 1'b0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_fill     <= n_fill;
            r_in_frame <= n_in_frame;
            r_sum      <= n_sum;
            if (w_flag_load || w_load_byte) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && r_in_frame) begin
            r_b1 <= w_b;
            r_b2 <= r_b1;
        end
        if (w_acc && w_trailer && w_ok) begin
            r_rd_addr   <= AW'(FIRST_BODY);
            r_last_addr <= w_ok_norm ? w_pos_m2[AW-1:0] : w_pos_m1[AW-1:0];
        end else if (w_load_byte && !w_rd_done) begin
            r_rd_addr <= r_rd_addr + AW'(1);
        end
        if (w_flag_load) begin
            r_out_byte <= '0;
            r_out_last <= 1'b0;
            r_out_user <= w_flag_user;
        end else if (w_load_byte) begin
            r_out_byte <= r_rd_data;
            r_out_last <= w_rd_done;
            r_out_user <= '{retransmit_request: 1'b0, send_nak: 1'b0, byte_valid: 1'b1};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_byte;
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_user;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= PW'(MAX_FILL))
        else $error("fill position beyond store");

    a_frame_has_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_frame |-> (r_fill >= PW'(2)))
        else $error("in frame without both header bytes");

    a_readout_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> (r_rd_addr <= r_last_addr))
        else $error("readout address past last byte");

    a_last_is_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast) |-> o_m_tuser[0])
        else $error("last flag on a non-byte result");

    a_no_input_in_readout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |=> !w_acc)
        else $error("input taken during frame readout");

endmodule

// ===== verif/uart_frame_receiver_tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench of the uart frame receiver: directed and random byte streams
module uart_frame_receiver_tb;
    import ufr_pkg::*;

    localparam int unsigned MAX_FILL    = 20;
    localparam int unsigned IDLE_PCT    = 14;
    localparam int unsigned ITEM_TARGET = 400;
    localparam int unsigned MAX_REPORTS = 10;
    localparam int unsigned TAIL_CYCLES = 2 * MAX_FILL + 60;
    localparam int unsigned STALL_LIMIT = 4000;

    typedef enum {
        FRM_NORMAL,
        FRM_ALT,
        FRM_BADSUM
    } frame_kind_e;

    typedef logic [7:0] byte_q_t[$];

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        t_out_user  user;
    } frame_result_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       rx_tvalid = 1'b0;
    logic       rx_tready;
    logic [7:0] rx_tdata  = 8'h00;
    logic [0:0] rx_tuser  = 1'b0;
    logic       fr_tvalid;
    logic       fr_tready = 1'b0;
    logic [7:0] fr_tdata;
    logic       fr_tlast;
    logic [2:0] fr_tuser;

    // deframer state as predicted from the accepted bytes
    logic [4:0] rx_fill     = '0;
    logic       rx_in_frame = 1'b0;
    logic [7:0] rx_sum      = '0;
    logic [7:0] rx_store [0:MAX_FILL];

    frame_result_t frame_out_q[$];
    int unsigned   items_sent   = 0;
    int unsigned   mismatch_cnt = 0;
    int unsigned   stall_cycles = 0;
    logic          steady       = 1'b0;

    uart_frame_receiver #(
        .MAX_FILL(MAX_FILL)
    ) dut (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_s_tvalid(rx_tvalid),
        .o_s_tready(rx_tready),
        .i_s_tdata (rx_tdata),
        .i_s_tuser (rx_tuser),
        .o_m_tvalid(fr_tvalid),
        .i_m_tready(fr_tready),
        .o_m_tdata (fr_tdata),
        .o_m_tlast (fr_tlast),
        .o_m_tuser (fr_tuser)
    );

    always #10 clk = ~clk;

    always @(negedge clk) begin
        fr_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    function automatic frame_result_t frame_result(logic [7:0] data, logic last, logic valid,
                                                   logic nak, logic rtx);
        frame_result.data                    = data;
        frame_result.last                    = last;
        frame_result.user.byte_valid         = valid;
        frame_result.user.send_nak           = nak;
        frame_result.user.retransmit_request = rtx;
    endfunction

    task automatic deframe_rx_byte(input logic [7:0] b, input logic ferr);
        logic [4:0]  pos;
        logic [7:0]  chk;
        logic [7:0]  body_sum;
        int unsigned last_pos;
        logic        pass;
        if (ferr)
            return;
        if (rx_in_frame) begin
            pos     = rx_fill + 5'd1;
            rx_fill = pos;
            if (pos <= MAX_FILL)
                rx_store[pos] = b;
            rx_sum = rx_sum + b;
            if (b == TRL_BYTE && pos > MIN_CLOSE_POS && pos <= MAX_FILL + 1 &&
                rx_store[pos - 5'd1] == TRL_BYTE) begin
                chk      = rx_store[pos - 5'd2];
                // the trailer pair adds exactly one header value to the sum
                body_sum = rx_sum - HDR_BYTE;
                pass     = 1'b0;
                last_pos = 0;
                if (8'(body_sum - chk) == chk) begin
                    last_pos = pos - 2;
                    pass     = 1'b1;
                end else if (body_sum == TRL_BYTE) begin
                    // checksum byte is itself 0x55, first trailer byte doubles as it
                    last_pos = pos - 1;
                    pass     = 1'b1;
                end
                if (pass) begin
                    for (int unsigned k = FIRST_BODY; k <= last_pos; k++)
                        frame_out_q.push_back(frame_result(rx_store[k], k == last_pos,
                                                           1'b1, 1'b0, 1'b0));
                end else begin
                    frame_out_q.push_back(frame_result(8'h00, 1'b0, 1'b0, 1'b1, 1'b0));
                end
                rx_sum      = '0;
                rx_in_frame = 1'b0;
                rx_fill     = '0;
            end
            // overlong frame is dropped but its sum carries over
            if (rx_fill > MAX_FILL) begin
                rx_fill     = '0;
                rx_in_frame = 1'b0;
            end
        end else if (b == HDR_BYTE) begin
            pos     = rx_fill + 5'd1;
            rx_fill = pos;
            if (pos <= MAX_FILL)
                rx_store[pos] = b;
            if (pos == 5'd2)
                rx_in_frame = 1'b1;
        end else begin
            rx_fill = '0;
            if (b == RTX_BYTE)
                frame_out_q.push_back(frame_result(8'h00, 1'b0, 1'b0, 1'b0, 1'b1));
        end
    endtask

    // entered and left just after a falling edge; valid stays high into the next request
    task automatic send_rx(input logic [7:0] b, input logic ferr);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            rx_tvalid <= 1'b0;
            @(negedge clk);
        end
        rx_tvalid <= 1'b1;
        rx_tdata  <= b;
        rx_tuser  <= ferr;
        do
            @(posedge clk);
        while (!rx_tready);
        deframe_rx_byte(b, ferr);
        if (!ferr)
            items_sent++;
        @(negedge clk);
    endtask

    task automatic send_body_byte(input logic [7:0] b, input int unsigned noise_pct);
        if ($urandom_range(0, 99) < noise_pct)
            send_rx(8'($urandom_range(0, 255)), 1'b1);
        send_rx(b, 1'b0);
    endtask

    // header, body, checksum byte of the given kind, trailer pair
    task automatic send_frame(input byte_q_t body, input frame_kind_e kind,
                              input int unsigned noise_pct);
        logic [7:0] sum;
        sum = '0;
        // get the deframer back to a clean hunt first
        while (rx_in_frame)
            send_rx(TRL_BYTE, 1'b0);
        if (rx_fill != 0)
            send_rx(8'h00, 1'b0);
        foreach (body[i])
            sum = sum + body[i];
        case (kind)
            FRM_NORMAL: body.push_back(sum);
            FRM_ALT:    body.push_back(TRL_BYTE - sum);
            default:    body.push_back(sum + 8'($urandom_range(1, 255)));
        endcase
        send_body_byte(HDR_BYTE, noise_pct);
        send_body_byte(HDR_BYTE, noise_pct);
        foreach (body[i])
            send_body_byte(body[i], noise_pct);
        send_body_byte(TRL_BYTE, noise_pct);
        send_body_byte(TRL_BYTE, noise_pct);
    endtask

    task automatic send_random_frame(input int unsigned len, input frame_kind_e kind,
                                     input int unsigned noise_pct);
        byte_q_t body;
        for (int unsigned i = 0; i < len; i++)
            body.push_back(8'($urandom_range(0, 255)));
        send_frame(body, kind, noise_pct);
    endtask

    task automatic note_mismatch(input string what, input frame_result_t want,
                                 input frame_result_t got);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
            $display("%0t mismatch (%s): expected byte %h last %b user %b, got byte %h last %b user %b",
                     $time, what, want.data, want.last, want.user,
                     got.data, got.last, got.user);
    endtask

    always @(posedge clk) begin
        frame_result_t got;
        frame_result_t want;
        string         bad;
        if (rst_n && fr_tvalid && fr_tready) begin
            got.data = fr_tdata;
            got.last = fr_tlast;
            got.user = fr_tuser;
            if (frame_out_q.size() == 0) begin
                note_mismatch("no request expected", '0, got);
            end else begin
                want = frame_out_q.pop_front();
                bad  = "";
                if (got.data !== want.data)
                    bad = {bad, " frame_byte"};
                if (got.last !== want.last)
                    bad = {bad, " last_byte"};
                if (got.user.byte_valid !== want.user.byte_valid)
                    bad = {bad, " byte_valid"};
                if (got.user.send_nak !== want.user.send_nak)
                    bad = {bad, " send_nak"};
                if (got.user.retransmit_request !== want.user.retransmit_request)
                    bad = {bad, " retransmit_request"};
                if (bad != "")
                    note_mismatch(bad, want, got);
            end
        end
    end

    // ends the run when neither side moves a request for too long
    always @(posedge clk) begin
        if (!rst_n || (rx_tvalid && rx_tready) || (fr_tvalid && fr_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("uart_frame_receiver regression: fail");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic test_retransmit;
        send_rx(RTX_BYTE, 1'b0);
        send_rx(RTX_BYTE, 1'b1);
        send_rx(HDR_BYTE, 1'b0);
        send_rx(RTX_BYTE, 1'b0);
    endtask

    task automatic test_basic_frames;
        byte_q_t body;
        send_frame(body, FRM_NORMAL, 0);
        body = {8'hFF};
        send_frame(body, FRM_NORMAL, 0);
        send_frame(body, FRM_BADSUM, 0);
    endtask

    task automatic test_alt_layout;
        byte_q_t body;
        // trailer pair at position four does not close, the third 0x55 does
        send_frame(body, FRM_ALT, 0);
    endtask

    task automatic test_broken_header;
        byte_q_t body;
        send_rx(HDR_BYTE, 1'b0);
        send_rx(8'h00, 1'b0);
        body = {8'h12};
        send_frame(body, FRM_NORMAL, 0);
    endtask

    task automatic test_frame_limits;
        // trailer completing at the position just past the store
        send_random_frame(MAX_FILL - 4, FRM_NORMAL, 0);
        send_random_frame(MAX_FILL - 4, FRM_ALT, 0);
        // overlong frame, then a frame that inherits its sum
        send_random_frame(MAX_FILL - 3, FRM_NORMAL, 0);
        send_random_frame(2, FRM_NORMAL, 0);
        send_random_frame(3, FRM_NORMAL, 0);
    endtask

    task automatic test_back_to_back;
        steady = 1'b1;
        for (int i = 0; i < 10; i++)
            send_random_frame($urandom_range(0, 10), FRM_NORMAL, 0);
        steady = 1'b0;
    endtask

    task automatic test_random_traffic;
        int unsigned roll;
        int unsigned len;
        frame_kind_e kind;
        while (items_sent < ITEM_TARGET) begin
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
                len  = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 8)
                                                   : $urandom_range(9, MAX_FILL - 3);
                roll = $urandom_range(0, 99);
                kind = (roll < 60) ? FRM_NORMAL : (roll < 80) ? FRM_ALT : FRM_BADSUM;
                send_random_frame(len, kind, 5);
            end else if (roll < 78) begin
                send_rx(RTX_BYTE, 1'($urandom_range(0, 1)));
            end else if (roll < 88) begin
                send_rx(($urandom_range(0, 1) != 0) ? HDR_BYTE : TRL_BYTE,
                        1'($urandom_range(0, 3) == 0));
            end else begin
                send_rx(8'($urandom_range(0, 255)), 1'($urandom_range(0, 3) == 0));
            end
        end
    endtask

    initial begin
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_retransmit();
        test_basic_frames();
        test_alt_layout();
        test_broken_header();
        test_frame_limits();
        test_back_to_back();
        test_random_traffic();
        rx_tvalid <= 1'b0;
        while (frame_out_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_cnt == 0) begin
            $display("uart_frame_receiver regression: pass");
        end else begin
            $display("uart_frame_receiver regression: fail");
        end
        $finish;
    end

endmodule
